>>> hdl/bas_pkg.sv
// Shared types for the batch ascending sorter: sequencer states and the
// control group the sequencer hands to the output register in the top level.
// No dependencies.
package bas_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } seq_state_t;

    typedef struct packed
    {
        logic load;
        logic last;
        logic drop;
    } out_ctl_t;

endpackage

>>> hdl/bas_store.sv
// Value store for the batch ascending sorter: one write port and one read
// port with registered read data. Uses bas_pkg for the data width.
module bas_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [bas_pkg::DATA_W-1:0]    wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic [bas_pkg::DATA_W-1:0]    rdata
);

    logic [bas_pkg::DATA_W-1:0] mem [DEPTH];
    logic [bas_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bas_seq.sv
// Sequencer of the batch ascending sorter: insertion by one shared signed
// comparator, one shift step per cycle, then the ordered read-out.
// Uses bas_pkg for states and the output control group; drives bas_store.
module bas_seq #(
    parameter int unsigned CAP = 64,
    parameter int unsigned AW  = 6,
    parameter int unsigned CW  = 7
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [bas_pkg::DATA_W-1:0]    value,
    input  logic                                 is_final,
    input  logic                                 out_free,
    output bas_pkg::out_ctl_t                    out_ctl,
    output logic                                 mem_we,
    output logic [AW-1:0]                        mem_waddr,
    output logic [bas_pkg::DATA_W-1:0]           mem_wdata,
    output logic                                 mem_re,
    output logic [AW-1:0]                        mem_raddr,
    input  logic [bas_pkg::DATA_W-1:0]           mem_rdata
);

    bas_pkg::seq_state_t               state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [AW-1:0]                     pos_reg, pos_next;
    logic [AW-1:0]                     idx_reg, idx_next;
    logic signed [bas_pkg::DATA_W-1:0] val_reg, val_next;
    logic                              last_reg, last_next;
    logic                              ovf_reg, ovf_next;
    logic                              greater;
    logic                              idx_is_last;

    // The one compare unit: stored neighbor above the new value?
    assign greater     = $signed(mem_rdata) > val_reg;
    assign idx_is_last = (CW'(idx_reg) + CW'(1)) == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bas_pkg::ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        ovf_next   = ovf_reg;
        in_ready   = 1'b0;
        out_ctl    = '0;
        mem_we     = 1'b0;
        mem_waddr  = pos_reg;
        mem_wdata  = val_reg;
        mem_re     = 1'b0;
        mem_raddr  = idx_reg;

        unique case (state_reg)
            bas_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    val_next  = value;
                    last_next = is_final;
                    idx_next  = '0;
                    if (count_reg >= CW'(CAP))
                    begin
                        // Store full: drop the item, remember the drop.
                        ovf_next = 1'b1;
                        if (is_final)
                        begin
                            state_next = bas_pkg::ST_EMIT_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = value;
                        count_next = count_reg + CW'(1);
                        if (is_final)
                        begin
                            state_next = bas_pkg::ST_EMIT_RD;
                        end
                    end
                    else
                    begin
                        pos_next   = count_reg[AW-1:0];
                        mem_re     = 1'b1;
                        mem_raddr  = count_reg[AW-1:0] - AW'(1);
                        state_next = bas_pkg::ST_SCAN;
                    end
                end
            end

            bas_pkg::ST_SCAN:
            begin
                mem_we = 1'b1;
                if (greater)
                begin
                    // Shift the neighbor up one slot and keep walking down.
                    mem_wdata = mem_rdata;
                    pos_next  = pos_reg - AW'(1);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = bas_pkg::ST_PLACE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_reg - AW'(2);
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = last_reg ? bas_pkg::ST_EMIT_RD : bas_pkg::ST_IDLE;
                end
            end

            bas_pkg::ST_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                count_next = count_reg + CW'(1);
                state_next = last_reg ? bas_pkg::ST_EMIT_RD : bas_pkg::ST_IDLE;
            end

            bas_pkg::ST_EMIT_RD:
            begin
                if (count_reg == '0)
                begin
                    ovf_next   = 1'b0;
                    state_next = bas_pkg::ST_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg;
                    state_next = bas_pkg::ST_EMIT_WAIT;
                end
            end

            bas_pkg::ST_EMIT_WAIT:
            begin
                if (out_free)
                begin
                    out_ctl.load = 1'b1;
                    out_ctl.last = idx_is_last;
                    out_ctl.drop = ovf_reg;
                    if (idx_is_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = bas_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = bas_pkg::ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = bas_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/batch_ascending_sorter_unit.sv
// Top level of the batch ascending sorter: store, sequencer and the output
// register. Depends on bas_pkg, bas_store and bas_seq.
//
// Collects a batch of signed 32-bit values, one per input item, keeping the
// store in ascending order by insertion; the item with is_final set is
// stored too and starts the read-out of the whole batch, smallest first, one
// value per output item, end_of_batch on the last. Items that arrive while
// BATCH_CAPACITY values are held are dropped, and every output item of that
// batch then carries dropped_any. Insertion: a value is inserted by a
// walk-down from the top of the store through the single signed comparator
// and the one-write/one-read store: an accept step, one shift per held
// value larger than it and a final step that writes the value into its
// slot, at the bottom as anywhere else; an item that is dropped or goes
// into an empty store is handled in the accept step alone. Read-out reads
// each value through the registered store read and then waits for the
// output register to be free. in_ready is low while an insertion or
// read-out is in progress. The output register lets a finished item wait
// for out_ready while the next batch is already being taken in.
module batch_ascending_sorter_unit #(
    parameter int unsigned BATCH_CAPACITY = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [bas_pkg::DATA_W-1:0]    value,
    input  logic                                 is_final,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [bas_pkg::DATA_W-1:0]    sorted_value,
    output logic                                 end_of_batch,
    output logic                                 dropped_any
);

    localparam int unsigned AW = $clog2(BATCH_CAPACITY);
    localparam int unsigned CW = $clog2(BATCH_CAPACITY + 1);

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [bas_pkg::DATA_W-1:0]    mem_wdata;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;
    logic [bas_pkg::DATA_W-1:0]    mem_rdata;
    bas_pkg::out_ctl_t             out_ctl;
    logic                          out_free;

    logic                              out_valid_reg;
    logic signed [bas_pkg::DATA_W-1:0] sorted_value_reg;
    logic                              end_reg;
    logic                              drop_reg;

    bas_store #(
        .DEPTH (BATCH_CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bas_seq #(
        .CAP (BATCH_CAPACITY),
        .AW  (AW),
        .CW  (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .is_final  (is_final),
        .out_free  (out_free),
        .out_ctl   (out_ctl),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // The output slot is free when empty or when its item leaves this cycle.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ctl.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload loads straight from the store's read register; hold otherwise.
    always_ff @(posedge clk)
    begin
        if (out_ctl.load)
        begin
            sorted_value_reg <= $signed(mem_rdata);
            end_reg          <= out_ctl.last;
            drop_reg         <= out_ctl.drop;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign end_of_batch = end_reg;
    assign dropped_any  = drop_reg;

endmodule
